@@ hdl/rmq_pkg.sv @@
// Shared types, sizes and datapath step functions for the rotation matrix to
// quaternion block. No dependencies.
package rmq_pkg;

	localparam int ElemW    = 16;
	localparam int TraceW   = 18;
	localparam int ArgW     = 17;
	localparam int DiffW    = 17;
	localparam int RadW     = 30;
	localparam int RootW    = 15;
	localparam int SqRemW   = 17;
	localparam int DvRemW   = 15;
	localparam int SqStages = RootW;
	localparam int DvStages = RadW;
	localparam int QDepth   = 4;
	localparam int QPtrW    = $clog2(QDepth);

	localparam logic [1:0] AXIS_W = 2'd0;
	localparam logic [1:0] AXIS_X = 2'd1;
	localparam logic [1:0] AXIS_Y = 2'd2;
	localparam logic [1:0] AXIS_Z = 2'd3;

	typedef struct packed {
		logic                    invalid;
		logic [1:0]              axis;
		logic [ArgW-1:0]         arg;
		logic signed [DiffW-1:0] d0;
		logic signed [DiffW-1:0] d1;
		logic signed [DiffW-1:0] d2;
	} rmq_item_t;

	typedef struct packed {
		logic signed [ElemW-1:0] qw;
		logic signed [ElemW-1:0] qx;
		logic signed [ElemW-1:0] qy;
		logic signed [ElemW-1:0] qz;
		logic [1:0]              axis;
		logic                    invalid;
	} rmq_res_t;

	typedef struct packed {
		logic                    valid;
		logic                    invalid;
		logic [1:0]              axis;
		logic signed [DiffW-1:0] d0;
		logic signed [DiffW-1:0] d1;
		logic signed [DiffW-1:0] d2;
		logic [RadW-1:0]         rad;
		logic [SqRemW-1:0]       rem;
		logic [RootW-1:0]        root;
	} rmq_sq_t;

	typedef struct packed {
		logic                         valid;
		logic                         invalid;
		logic [1:0]                   axis;
		logic [RootW-1:0]             root;
		logic [2:0]                   neg;
		logic [2:0][RadW-1:0]         num;
		logic [2:0][DvRemW-1:0]       rem;
		logic [2:0][RadW-1:0]         quo;
	} rmq_dv_t;

	// one bit of the integer square root, taking two radicand bits per step
	function automatic rmq_sq_t sq_step(input rmq_sq_t s);
		rmq_sq_t           o;
		logic [SqRemW+1:0] pre;
		logic [SqRemW+1:0] trial;
		o     = s;
		pre   = {s.rem, s.rad[RadW-1 -: 2]};
		trial = (SqRemW+2)'({s.root, 2'b01});
		if (pre >= trial) begin
			o.rem  = SqRemW'(pre - trial);
			o.root = {s.root[RootW-2:0], 1'b1};
		end else begin
			o.rem  = SqRemW'(pre);
			o.root = {s.root[RootW-2:0], 1'b0};
		end
		o.rad = {s.rad[RadW-3:0], 2'b00};
		return o;
	endfunction

	// one quotient bit for each of the three restoring dividers
	function automatic rmq_dv_t dv_step(input rmq_dv_t s);
		rmq_dv_t         o;
		logic [DvRemW:0] pre;
		logic [DvRemW:0] dvs;
		o   = s;
		dvs = (DvRemW+1)'(s.root);
		for (int j = 0; j < 3; j++) begin
			pre = {s.rem[j], s.num[j][RadW-1]};
			if (pre >= dvs) begin
				o.rem[j] = DvRemW'(pre - dvs);
				o.quo[j] = {s.quo[j][RadW-2:0], 1'b1};
			end else begin
				o.rem[j] = DvRemW'(pre);
				o.quo[j] = {s.quo[j][RadW-2:0], 1'b0};
			end
			o.num[j] = {s.num[j][RadW-2:0], 1'b0};
		end
		return o;
	endfunction

	function automatic logic signed [ElemW-1:0] sat_q(input logic neg,
		input logic [RadW-1:0] q);
		logic signed [ElemW-1:0] r;
		if (neg) begin
			if (q > RadW'(32768)) r = 16'sh8000;
			else                  r = ElemW'(16'd0 - q[ElemW-1:0]);
		end else begin
			if (q > RadW'(32767)) r = 16'sh7fff;
			else                  r = q[ElemW-1:0];
		end
		return r;
	endfunction

endpackage

@@ hdl/rmq_front.sv @@
// Front end: forms the four trace combinations, picks the largest and
// selects the three off-diagonal terms. Depends on rmq_pkg.
module rmq_front import rmq_pkg::*; (
	input  logic signed [ElemW-1:0] e00,
	input  logic signed [ElemW-1:0] e01,
	input  logic signed [ElemW-1:0] e02,
	input  logic signed [ElemW-1:0] e10,
	input  logic signed [ElemW-1:0] e11,
	input  logic signed [ElemW-1:0] e12,
	input  logic signed [ElemW-1:0] e20,
	input  logic signed [ElemW-1:0] e21,
	input  logic signed [ElemW-1:0] e22,
	output rmq_item_t               item
);

	logic signed [TraceW-1:0] a00, a11, a22;
	logic signed [TraceW-1:0] t0, t1, t2, t3, best;
	logic signed [TraceW:0]   arg;
	logic [1:0]               axis;
	logic signed [DiffW-1:0]  s21m12, s02m20, s10m01, s10p01, s02p20, s21p12;
	logic                     bad;

	assign a00 = TraceW'(e00);
	assign a11 = TraceW'(e11);
	assign a22 = TraceW'(e22);
	assign t0  = a00 + a11 + a22;
	assign t1  = a00 - a11 - a22;
	assign t2  = a11 - a00 - a22;
	assign t3  = a22 - a00 - a11;

	assign s21m12 = DiffW'(e21) - DiffW'(e12);
	assign s02m20 = DiffW'(e02) - DiffW'(e20);
	assign s10m01 = DiffW'(e10) - DiffW'(e01);
	assign s10p01 = DiffW'(e10) + DiffW'(e01);
	assign s02p20 = DiffW'(e02) + DiffW'(e20);
	assign s21p12 = DiffW'(e21) + DiffW'(e12);

	always_comb begin
		best = t0;
		axis = AXIS_W;
		if (t1 > best) begin
			best = t1;
			axis = AXIS_X;
		end
		if (t2 > best) begin
			best = t2;
			axis = AXIS_Y;
		end
		if (t3 > best) begin
			best = t3;
			axis = AXIS_Z;
		end
	end

	assign arg = (TraceW+1)'(best) + (TraceW+1)'(16384);
	assign bad = (arg <= 0);

	always_comb begin
		item.invalid = bad;
		item.axis    = bad ? AXIS_W : axis;
		item.arg     = bad ? '0 : arg[ArgW-1:0];
		unique case (axis)
			AXIS_W: begin
				item.d0 = s21m12; item.d1 = s02m20; item.d2 = s10m01;
			end
			AXIS_X: begin
				item.d0 = s21m12; item.d1 = s10p01; item.d2 = s02p20;
			end
			AXIS_Y: begin
				item.d0 = s02m20; item.d1 = s10p01; item.d2 = s21p12;
			end
			default: begin
				item.d0 = s10m01; item.d1 = s02p20; item.d2 = s21p12;
			end
		endcase
	end

endmodule

@@ hdl/rmq_queue.sv @@
// Short queue between the front end and the arithmetic back end.
// Depends on rmq_pkg.
module rmq_queue import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  rmq_item_t wr_item,
	output logic      full,
	input  logic      pop,
	output rmq_item_t rd_item,
	output logic      empty
);

	rmq_item_t        mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPtrW:0]   count_q;
	logic             do_push, do_pop;

	assign full    = (count_q == (QPtrW+1)'(QDepth));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (QPtrW+1)'(do_push) - (QPtrW+1)'(do_pop);
		end
	end

endmodule

@@ hdl/rmq_back.sv @@
// Back end: pipelined square root, three pipelined dividers, saturation and
// a two-entry result queue. Depends on rmq_pkg.
module rmq_back import rmq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  rmq_item_t item,
	input  logic      item_empty,
	output logic      item_pop,
	output rmq_res_t  res,
	output logic      empty,
	input  logic      pop
);

	rmq_sq_t  sq_q [SqStages+1];
	rmq_dv_t  dv_q [DvStages+1];
	rmq_res_t oq_q [2];
	logic     wr_q, rd_q;
	logic [1:0] cnt_q;
	logic     ofull, adv, opush, opop;
	rmq_dv_t  dv_in;
	rmq_res_t fin;
	logic signed [ElemW-1:0] c0, c1, c2, r16;

	assign ofull    = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign adv      = !(dv_q[DvStages].valid && ofull);
	assign item_pop = adv && !item_empty;
	assign opush    = dv_q[DvStages].valid && !ofull;
	assign opop     = pop && !empty;
	assign res      = oq_q[rd_q];

	always_comb begin
		logic signed [DiffW-1:0] d [3];
		logic [DiffW-1:0]        mag;
		rmq_sq_t                 s;
		s       = sq_q[SqStages];
		d[0]    = s.d0;
		d[1]    = s.d1;
		d[2]    = s.d2;
		dv_in.valid   = s.valid;
		dv_in.invalid = s.invalid;
		dv_in.axis    = s.axis;
		dv_in.root    = s.root;
		for (int j = 0; j < 3; j++) begin
			dv_in.neg[j] = d[j][DiffW-1];
			mag          = d[j][DiffW-1] ? DiffW'(17'd0 - d[j]) : d[j];
			dv_in.num[j] = RadW'({mag, 12'b0}) + RadW'(s.root[RootW-1:1]);
			dv_in.rem[j] = '0;
			dv_in.quo[j] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= SqStages; k++) sq_q[k] <= '0;
			for (int k = 0; k <= DvStages; k++) dv_q[k] <= '0;
		end else if (adv) begin
			sq_q[0].valid   <= item_pop;
			sq_q[0].invalid <= item.invalid;
			sq_q[0].axis    <= item.axis;
			sq_q[0].d0      <= item.d0;
			sq_q[0].d1      <= item.d1;
			sq_q[0].d2      <= item.d2;
			sq_q[0].rad     <= RadW'({item.arg, 12'b0});
			sq_q[0].rem     <= '0;
			sq_q[0].root    <= '0;
			for (int k = 1; k <= SqStages; k++) sq_q[k] <= sq_step(sq_q[k-1]);
			dv_q[0] <= dv_in;
			for (int k = 1; k <= DvStages; k++) dv_q[k] <= dv_step(dv_q[k-1]);
		end
	end

	assign c0  = sat_q(dv_q[DvStages].neg[0], dv_q[DvStages].quo[0]);
	assign c1  = sat_q(dv_q[DvStages].neg[1], dv_q[DvStages].quo[1]);
	assign c2  = sat_q(dv_q[DvStages].neg[2], dv_q[DvStages].quo[2]);
	assign r16 = ElemW'(dv_q[DvStages].root);

	always_comb begin
		fin.axis    = dv_q[DvStages].axis;
		fin.invalid = dv_q[DvStages].invalid;
		unique case (dv_q[DvStages].axis)
			AXIS_W: begin
				fin.qw = r16; fin.qx = c0; fin.qy = c1; fin.qz = c2;
			end
			AXIS_X: begin
				fin.qw = c0; fin.qx = r16; fin.qy = c1; fin.qz = c2;
			end
			AXIS_Y: begin
				fin.qw = c0; fin.qx = c1; fin.qy = r16; fin.qz = c2;
			end
			default: begin
				fin.qw = c0; fin.qx = c1; fin.qy = c2; fin.qz = r16;
			end
		endcase
		if (dv_q[DvStages].invalid) begin
			fin.qw   = '0;
			fin.qx   = '0;
			fin.qy   = '0;
			fin.qz   = '0;
			fin.axis = AXIS_W;
		end
	end

	always_ff @(posedge clk) begin
		if (opush) oq_q[wr_q] <= fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (opush) wr_q <= !wr_q;
			if (opop)  rd_q <= !rd_q;
			cnt_q <= cnt_q + 2'(opush) - 2'(opop);
		end
	end

endmodule

@@ hdl/rotation_matrix_to_quaternion_top.sv @@
// Rotation matrix (Q2.14) to unit quaternion, Shepperd's method.
// Path from push to result: input queue, 16 root stages, 31 divider stages,
// result queue. Throughput: one matrix per cycle unless the result queue is full,
// set by the one-digit-per-stage root and dividers.
// Reset: arst_n clears all queues and pipeline valids; no clearing pass.
// Depends on rmq_pkg, rmq_front, rmq_queue, rmq_back.
module rotation_matrix_to_quaternion_top import rmq_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	output logic                    full,
	input  logic signed [ElemW-1:0] e00,
	input  logic signed [ElemW-1:0] e01,
	input  logic signed [ElemW-1:0] e02,
	input  logic signed [ElemW-1:0] e10,
	input  logic signed [ElemW-1:0] e11,
	input  logic signed [ElemW-1:0] e12,
	input  logic signed [ElemW-1:0] e20,
	input  logic signed [ElemW-1:0] e21,
	input  logic signed [ElemW-1:0] e22,
	output logic                    empty,
	input  logic                    pop,
	output logic signed [ElemW-1:0] qw,
	output logic signed [ElemW-1:0] qx,
	output logic signed [ElemW-1:0] qy,
	output logic signed [ElemW-1:0] qz,
	output logic [1:0]              largest_axis,
	output logic                    invalid
);

	rmq_item_t f_item, q_item;
	logic      q_empty, q_pop;
	rmq_res_t  res;

	rmq_front u_front (
		.e00(e00), .e01(e01), .e02(e02),
		.e10(e10), .e11(e11), .e12(e12),
		.e20(e20), .e21(e21), .e22(e22),
		.item(f_item)
	);

	rmq_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .wr_item(f_item), .full(full),
		.pop(q_pop), .rd_item(q_item), .empty(q_empty)
	);

	rmq_back u_back (
		.clk(clk), .arst_n(arst_n),
		.item(q_item), .item_empty(q_empty), .item_pop(q_pop),
		.res(res), .empty(empty), .pop(pop)
	);

	assign qw           = res.qw;
	assign qx           = res.qx;
	assign qy           = res.qy;
	assign qz           = res.qz;
	assign largest_axis = res.axis;
	assign invalid      = res.invalid;

endmodule
